FILE: src/irbb_pkg.sv
// Package for the rotate block: configuration register indexes and field widths.
package irbb_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS_Q      = 3'd0,
    CFG_SIN_Q      = 3'd1,
    CFG_ROW_OFFSET = 3'd2,
    CFG_COL_OFFSET = 3'd3,
    CFG_SRC_ROWS   = 3'd4,
    CFG_SRC_COLS   = 3'd5
  } cfg_idx_t;

  localparam int TRIG_W = 16;
  localparam int OFS_W = 18;
  localparam int DIM_W = 10;
  localparam int PIX_W = 10;
  localparam int CH_W = 8;
  localparam int RGB_W = 3 * CH_W;

  localparam logic signed [TRIG_W-1:0] COS_RESET = 16'sd16384;

endpackage

FILE: src/image_rotate_backward_bilinear.sv
// Top level of the backward-mapping rotator with bilinear blending.
// Takes one item per cycle, writes and queries alike, while the output is
// not stalled; query results leave in the order their queries were accepted.
// The rate is set by the source frame store, which is split into four banks
// by row and column parity, so the four neighbours of a query fall in four
// different banks and are read in the same cycle. A stall at the output
// holds the whole pipeline. Configuration is taken at once (cfg_ready is
// always high) and must be written while no query is in flight.
module image_rotate_backward_bilinear #(
  parameter int MAX_DIM = 512,
  parameter int TRIG_FRAC_BITS = 14,
  parameter int POS_FRAC_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [irbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irbb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic req_type,
  input  logic [irbb_pkg::PIX_W-1:0] pix_row,
  input  logic [irbb_pkg::PIX_W-1:0] pix_col,
  input  logic [irbb_pkg::CH_W-1:0] in_blue,
  input  logic [irbb_pkg::CH_W-1:0] in_green,
  input  logic [irbb_pkg::CH_W-1:0] in_red,
  output logic out_valid,
  input  logic out_stall,
  output logic [irbb_pkg::CH_W-1:0] out_blue,
  output logic [irbb_pkg::CH_W-1:0] out_green,
  output logic [irbb_pkg::CH_W-1:0] out_red,
  output logic inside_res
);
  import irbb_pkg::*;

  localparam int P = POS_FRAC_BITS;
  localparam int DW = ((PIX_W + P > OFS_W) ? PIX_W + P : OFS_W) + 1;
  localparam int PW = TRIG_W + DW;
  localparam int SW = PW + 1;
  localparam int RW = SW - TRIG_FRAC_BITS;
  localparam int IRW = RW - 1 - P;
  localparam int CW = ((IRW > DIM_W + 2) ? IRW : DIM_W + 2) + 1;
  localparam int AW = $clog2(MAX_DIM);
  localparam int BAW = 2 * (AW - 1);
  localparam int BANK_DEPTH = 1 << BAW;
  localparam int WW = 2 * P + 1;
  localparam int MW = WW + CH_W;
  localparam int AccW = MW + 2;

  // configuration
  logic signed [TRIG_W-1:0] cos_q, sin_q;
  logic [OFS_W-1:0] row_offset, col_offset;
  logic [DIM_W-1:0] src_rows, src_cols;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_q <= COS_RESET;
      sin_q <= '0;
      row_offset <= '0;
      col_offset <= '0;
      src_rows <= DIM_W'(512);
      src_cols <= DIM_W'(512);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COS_Q:      cos_q <= cfg_data[TRIG_W-1:0];
        CFG_SIN_Q:      sin_q <= cfg_data[TRIG_W-1:0];
        CFG_ROW_OFFSET: row_offset <= cfg_data[OFS_W-1:0];
        CFG_COL_OFFSET: col_offset <= cfg_data[OFS_W-1:0];
        CFG_SRC_ROWS:   src_rows <= cfg_data[DIM_W-1:0];
        CFG_SRC_COLS:   src_cols <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic en;
  logic v1, v2, v3, v4, v5, v6;
  logic q1, q2, q3, q4, q5, q6;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5;
      out_valid <= v6 && q6;
    end
  end

  // stage 1: input
  logic [PIX_W-1:0] s1_row, s1_col;
  logic [RGB_W-1:0] s1_rgb;

  always_ff @(posedge clk) begin
    if (en) begin
      q1 <= req_type;
      s1_row <= pix_row;
      s1_col <= pix_col;
      s1_rgb <= {in_red, in_green, in_blue};
    end
  end

  // stage 2: offsets
  logic signed [DW-1:0] s2_dr, s2_dc;
  logic [PIX_W-1:0] s2_row, s2_col;
  logic [RGB_W-1:0] s2_rgb;

  always_ff @(posedge clk) begin
    if (en) begin
      q2 <= q1;
      s2_row <= s1_row;
      s2_col <= s1_col;
      s2_rgb <= s1_rgb;
      s2_dr <= signed'((DW'(s1_row) << P) - DW'(row_offset));
      s2_dc <= signed'((DW'(s1_col) << P) - DW'(col_offset));
    end
  end

  // stage 3: products
  logic signed [PW-1:0] s3_crr, s3_sdc, s3_cdc, s3_sdr;
  logic [PIX_W-1:0] s3_row, s3_col;
  logic [RGB_W-1:0] s3_rgb;

  always_ff @(posedge clk) begin
    if (en) begin
      q3 <= q2;
      s3_row <= s2_row;
      s3_col <= s2_col;
      s3_rgb <= s2_rgb;
      s3_crr <= PW'(cos_q) * PW'(s2_dr);
      s3_sdc <= PW'(sin_q) * PW'(s2_dc);
      s3_cdc <= PW'(cos_q) * PW'(s2_dc);
      s3_sdr <= PW'(sin_q) * PW'(s2_dr);
    end
  end

  // stage 4: sums, floor to position fraction
  logic signed [SW-1:0] sr_full, sc_full;
  logic signed [RW-1:0] s4_sr, s4_sc;
  logic [PIX_W-1:0] s4_row, s4_col;
  logic [RGB_W-1:0] s4_rgb;

  assign sr_full = SW'(s3_crr) + SW'(s3_sdc);
  assign sc_full = SW'(s3_cdc) - SW'(s3_sdr);

  always_ff @(posedge clk) begin
    if (en) begin
      q4 <= q3;
      s4_row <= s3_row;
      s4_col <= s3_col;
      s4_rgb <= s3_rgb;
      s4_sr <= sr_full[SW-1:TRIG_FRAC_BITS];
      s4_sc <= sc_full[SW-1:TRIG_FRAC_BITS];
    end
  end

  // stage 4 logic: bounds, weights, bank addresses
  logic [IRW-1:0] ir, ic;
  logic [P-1:0] fr, fc;
  logic [P:0] gr, gc;
  logic [CW-1:0] rows_c, cols_c;
  logic in_src;
  logic [AW-1:0] ir_a, ic_a, ir_a1, ic_a1, wr_r, wr_c;
  logic wr_en;
  logic [1:0] wr_bank;
  logic [BAW-1:0] wr_addr;
  logic [BAW-1:0] rd_addr [4];

  assign ir = s4_sr[RW-2:P];
  assign ic = s4_sc[RW-2:P];
  assign fr = s4_sr[P-1:0];
  assign fc = s4_sc[P-1:0];
  assign gr = (P+1)'(1 << P) - (P+1)'(fr);
  assign gc = (P+1)'(1 << P) - (P+1)'(fc);
  assign rows_c = (CW'(src_rows) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(src_rows);
  assign cols_c = (CW'(src_cols) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(src_cols);
  assign in_src = !s4_sr[RW-1] && !s4_sc[RW-1]
                  && (CW'(ir) + CW'(1) < rows_c) && (CW'(ic) + CW'(1) < cols_c);

  assign ir_a = AW'(ir);
  assign ic_a = AW'(ic);
  assign ir_a1 = ir_a + AW'(1);
  assign ic_a1 = ic_a + AW'(1);

  assign wr_r = AW'(s4_row);
  assign wr_c = AW'(s4_col);
  assign wr_en = en && v4 && !q4 && (int'(s4_row) < MAX_DIM) && (int'(s4_col) < MAX_DIM);
  assign wr_bank = {wr_r[0], wr_c[0]};
  assign wr_addr = {wr_r[AW-1:1], wr_c[AW-1:1]};

  logic [RGB_W-1:0] rd_data [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [RGB_W-1:0] mem [BANK_DEPTH];
    logic [AW-1:0] br, bc;

    assign br = (ir_a[0] == b[1]) ? ir_a : ir_a1;
    assign bc = (ic_a[0] == b[0]) ? ic_a : ic_a1;
    assign rd_addr[b] = {br[AW-1:1], bc[AW-1:1]};

    always_ff @(posedge clk) begin
      if (wr_en && wr_bank == 2'(b)) begin
        mem[wr_addr] <= s4_rgb;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rd_data[b] <= mem[rd_addr[b]];
      end
    end
  end

  // stage 5: neighbour data and weights
  logic s5_ir0, s5_ic0, s5_in;
  logic [WW-1:0] s5_w [4];

  always_ff @(posedge clk) begin
    if (en) begin
      q5 <= q4;
      s5_in <= in_src;
      s5_ir0 <= ir_a[0];
      s5_ic0 <= ic_a[0];
      s5_w[0] <= WW'(gr) * WW'(gc);
      s5_w[1] <= WW'(gr) * WW'(fc);
      s5_w[2] <= WW'(fr) * WW'(gc);
      s5_w[3] <= WW'(fr) * WW'(fc);
    end
  end

  // stage 6: weighted channels
  logic [MW-1:0] s6_prod [3][4];
  logic s6_in;

  always_ff @(posedge clk) begin
    if (en) begin
      q6 <= q5;
      s6_in <= s5_in;
      for (int n = 0; n < 4; n++) begin
        for (int k = 0; k < 3; k++) begin
          s6_prod[k][n] <= MW'(s5_w[n])
            * MW'(rd_data[{s5_ir0 ^ n[1], s5_ic0 ^ n[0]}][k*CH_W +: CH_W]);
        end
      end
    end
  end

  // stage 7: sum and output
  logic [AccW-1:0] acc [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = AccW'(s6_prod[k][0]) + AccW'(s6_prod[k][1])
             + AccW'(s6_prod[k][2]) + AccW'(s6_prod[k][3]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inside_res <= s6_in;
      out_blue  <= s6_in ? acc[0][2*P +: CH_W] : '0;
      out_green <= s6_in ? acc[1][2*P +: CH_W] : '0;
      out_red   <= s6_in ? acc[2][2*P +: CH_W] : '0;
    end
  end

`ifndef SYNTHESIS
  a_outside_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && !inside_res |-> out_blue == '0 && out_green == '0 && out_red == '0)
    else $error("outside result not black");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output stalled");

  a_weight_sum: assert property (@(posedge clk) disable iff (rst)
    v5 && q5 |-> (AccW'(s5_w[0]) + AccW'(s5_w[1]) + AccW'(s5_w[2]) + AccW'(s5_w[3]))
                 == AccW'(1) << (2 * P))
    else $error("bilinear weights do not sum to one");

  a_only_queries_out: assert property (@(posedge clk) disable iff (rst)
    en && !(v6 && q6) |=> !out_valid)
    else $error("result without a query");
`endif

endmodule

FILE: verif/image_rotate_backward_bilinear_tb.sv
// Self-checking testbench for the backward-mapping bilinear image rotator.
`timescale 1ns / 1ps

module image_rotate_backward_bilinear_tb;
  import irbb_pkg::*;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;
  localparam int DIM = 512;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic hit;
  } pixel_res_t;

  typedef struct {
    logic req;
    int row;
    int col;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    bit typed;
    pixel_res_t res;
  } stim_row_t;

  typedef struct {
    int cos_v;
    int sin_v;
    int row_ofs;
    int col_ofs;
    int rows;
    int cols;
    int count;
  } rot_setting_t;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic req_type;
  logic [PIX_W-1:0] pix_row;
  logic [PIX_W-1:0] pix_col;
  logic [CH_W-1:0] in_blue;
  logic [CH_W-1:0] in_green;
  logic [CH_W-1:0] in_red;
  logic out_valid;
  logic out_stall;
  logic [CH_W-1:0] out_blue;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_red;
  logic inside_res;

  image_rotate_backward_bilinear i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .pix_row(pix_row), .pix_col(pix_col),
    .in_blue(in_blue), .in_green(in_green), .in_red(in_red),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_blue(out_blue), .out_green(out_green), .out_red(out_red), .inside_res(inside_res)
  );

  // mirror of the block's state
  logic [RGB_W-1:0] frame_mirror [0:DIM*DIM-1];
  bit frame_written [0:DIM*DIM-1];
  longint rot_cos = 16384;
  longint rot_sin = 0;
  longint ofs_row = 0;
  longint ofs_col = 0;
  int rows_cfg = 512;
  int cols_cfg = 512;

  pixel_res_t pending_px [$];
  int error_count = 0;
  int idle_cycles = 0;
  int queries_sent = 0;
  int inside_seen = 0;
  int writes_sent = 0;
  int pixels_checked = 0;
  bit send_calm = 0;
  bit recv_calm = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void map_back(input int row, input int col, output bit ins,
                                   output longint ir, output longint ic,
                                   output longint fr, output longint fc);
    longint dr, dc, sr, sc;
    int rows_eff, cols_eff;
    dr = longint'(row) * 256 - ofs_row;
    dc = longint'(col) * 256 - ofs_col;
    sr = (rot_cos * dr + rot_sin * dc) >>> 14;
    sc = (rot_cos * dc - rot_sin * dr) >>> 14;
    rows_eff = (rows_cfg > DIM) ? DIM : rows_cfg;
    cols_eff = (cols_cfg > DIM) ? DIM : cols_cfg;
    ir = sr >>> 8;
    ic = sc >>> 8;
    fr = sr & 255;
    fc = sc & 255;
    ins = !(sr < 0 || sc < 0) && (ir + 1 < rows_eff) && (ic + 1 < cols_eff);
  endfunction

  function automatic pixel_res_t blend_pixel(input int row, input int col);
    pixel_res_t res;
    bit ins;
    longint ir, ic, fr, fc, acc;
    longint wt [4];
    logic [RGB_W-1:0] px [4];
    res = '0;
    map_back(row, col, ins, ir, ic, fr, fc);
    if (ins) begin
      wt[0] = (256 - fr) * (256 - fc);
      wt[1] = (256 - fr) * fc;
      wt[2] = fr * (256 - fc);
      wt[3] = fr * fc;
      px[0] = frame_mirror[ir * DIM + ic];
      px[1] = frame_mirror[ir * DIM + ic + 1];
      px[2] = frame_mirror[(ir + 1) * DIM + ic];
      px[3] = frame_mirror[(ir + 1) * DIM + ic + 1];
      for (int k = 0; k < 3; k++) begin
        acc = 0;
        for (int n = 0; n < 4; n++) acc += wt[n] * ((px[n] >> (8 * k)) & 255);
        acc = (acc >> 16) & 255;
        if (k == 0) res.blue = acc[7:0];
        else if (k == 1) res.green = acc[7:0];
        else res.red = acc[7:0];
      end
      res.hit = 1'b1;
    end
    return res;
  endfunction

  task automatic send_item(input logic req, input int row, input int col,
                           input logic [CH_W-1:0] b, input logic [CH_W-1:0] g,
                           input logic [CH_W-1:0] r, input bit typed, input pixel_res_t res);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type = req;
    pix_row = row[PIX_W-1:0];
    pix_col = col[PIX_W-1:0];
    in_blue = b;
    in_green = g;
    in_red = r;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    if (req == REQ_WRITE) begin
      writes_sent++;
      if (row < DIM && col < DIM) begin
        frame_mirror[row * DIM + col] = {r, g, b};
        frame_written[row * DIM + col] = 1'b1;
      end
    end else begin
      queries_sent++;
      pending_px.push_back(typed ? res : blend_pixel(row, col));
    end
    @(negedge clk);
  endtask

  task automatic query_pixel(input int row, input int col, input bit typed, input pixel_res_t res);
    bit ins;
    longint ir, ic, fr, fc;
    int nr, nc;
    map_back(row, col, ins, ir, ic, fr, fc);
    if (ins) begin
      for (int n = 0; n < 4; n++) begin
        nr = int'(ir) + n / 2;
        nc = int'(ic) + n % 2;
        if (!frame_written[nr * DIM + nc])
          send_item(REQ_WRITE, nr, nc, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom),
                    1'b0, '0);
      end
    end
    send_item(REQ_QUERY, row, col, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom),
              typed, res);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int value);
    cfg_index = idx;
    cfg_data = value[CFG_DATA_W-1:0];
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_COS_Q: rot_cos = longint'($signed(value[15:0]));
      CFG_SIN_Q: rot_sin = longint'($signed(value[15:0]));
      CFG_ROW_OFFSET: ofs_row = value & 32'h3FFFF;
      CFG_COL_OFFSET: ofs_col = value & 32'h3FFFF;
      CFG_SRC_ROWS: rows_cfg = value & 32'h3FF;
      CFG_SRC_COLS: cols_cfg = value & 32'h3FF;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_px.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // receiver: random stall per item, with calm stretches
  initial begin
    int hold;
    out_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) recv_calm = ~recv_calm;
      hold = recv_calm ? 0 : $urandom_range(0, 11);
      out_stall = (hold > 0);
      repeat (hold) @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      pixel_res_t want;
      if (pending_px.size() == 0) begin
        $error("result with no query outstanding");
        error_count++;
      end else begin
        want = pending_px.pop_front();
        pixels_checked++;
        if (inside_res) inside_seen++;
        if (out_blue !== want.blue) begin
          $error("out_blue expected %0d actual %0d", want.blue, out_blue);
          error_count++;
        end
        if (out_green !== want.green) begin
          $error("out_green expected %0d actual %0d", want.green, out_green);
          error_count++;
        end
        if (out_red !== want.red) begin
          $error("out_red expected %0d actual %0d", want.red, out_red);
          error_count++;
        end
        if (inside_res !== want.hit) begin
          $error("inside_res expected %0d actual %0d", want.hit, inside_res);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    stim_row_t dir_rows [$];
    rot_setting_t settings [$];
    rot_setting_t s;
    int row, col;

    dir_rows = '{
      '{REQ_WRITE, 0, 0, 8'd255, 8'd255, 8'd255, 1'b0, '0},
      '{REQ_WRITE, 0, 1, 8'd0, 8'd0, 8'd0, 1'b0, '0},
      '{REQ_WRITE, 1, 0, 8'd1, 8'd2, 8'd3, 1'b0, '0},
      '{REQ_WRITE, 1, 1, 8'd128, 8'd64, 8'd32, 1'b0, '0},
      '{REQ_QUERY, 0, 0, 8'd0, 8'd0, 8'd0, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b1}},
      '{REQ_QUERY, 1, 0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
      '{REQ_WRITE, 600, 5, 8'd9, 8'd9, 8'd9, 1'b0, '0},
      '{REQ_WRITE, 5, 1023, 8'd7, 8'd7, 8'd7, 1'b0, '0},
      '{REQ_WRITE, 1023, 1023, 8'd255, 8'd0, 8'd255, 1'b0, '0},
      '{REQ_QUERY, 511, 0, 8'd255, 8'd255, 8'd255, 1'b1, '0},
      '{REQ_QUERY, 0, 511, 8'd0, 8'd0, 8'd0, 1'b1, '0},
      '{REQ_QUERY, 1023, 1023, 8'd0, 8'd0, 8'd0, 1'b1, '0},
      '{REQ_WRITE, 511, 511, 8'd255, 8'd255, 8'd255, 1'b0, '0},
      '{REQ_QUERY, 510, 510, 8'd0, 8'd0, 8'd0, 1'b0, '0},
      '{REQ_QUERY, 509, 3, 8'd0, 8'd0, 8'd0, 1'b0, '0}
    };

    settings = '{
      '{16384, 0, 128, 64, 511, 512, 75},
      '{11585, 11585, 0, 0, 512, 512, 75},
      '{-16384, 0, 262143, 262143, 512, 512, 75},
      '{0, 16384, 262143, 0, 512, 512, 75},
      '{0, -16384, 0, 262143, 1023, 2, 60},
      '{13377, -9459, 0, 30000, 300, 200, 75},
      '{0, 0, 0, 0, 0, 1, 15},
      '{15137, 6270, 200, 77777, 64, 600, 75}
    };

    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    req_type = REQ_WRITE;
    pix_row = '0;
    pix_col = '0;
    in_blue = '0;
    in_green = '0;
    in_red = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].req == REQ_WRITE)
        send_item(REQ_WRITE, dir_rows[i].row, dir_rows[i].col, dir_rows[i].blue,
                  dir_rows[i].green, dir_rows[i].red, 1'b0, '0);
      else
        query_pixel(dir_rows[i].row, dir_rows[i].col, dir_rows[i].typed, dir_rows[i].res);
    end

    foreach (settings[p]) begin
      s = settings[p];
      wait_drained();
      write_reg(CFG_COS_Q, s.cos_v & 32'hFFFF);
      write_reg(CFG_SIN_Q, s.sin_v & 32'hFFFF);
      write_reg(CFG_ROW_OFFSET, s.row_ofs);
      write_reg(CFG_COL_OFFSET, s.col_ofs);
      write_reg(CFG_SRC_ROWS, s.rows);
      write_reg(CFG_SRC_COLS, s.cols);
      for (int n = 0; n < s.count; n++) begin
        if ($urandom_range(0, 49) == 0) send_calm = ~send_calm;
        if ($urandom_range(0, 3) == 0) begin
          row = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 511);
          col = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 511);
          send_item(REQ_WRITE, row, col, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom),
                    1'b0, '0);
        end else begin
          row = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 399);
          col = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 399);
          query_pixel(row, col, 1'b0, '0);
        end
      end
    end

    wait_drained();
    $display("covered %0d writes and %0d queries over %0d rotation settings",
             writes_sent, queries_sent, settings.size());
    $display("checked %0d pixels, %0d inside the source", pixels_checked, inside_seen);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
